### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, masked while rst_n low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LZSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lzss_pkg.sv
// ---------------------------------------------------------------------------
// lzss_pkg
// Shared constants and types for the LZSS ring decompressor.
// ---------------------------------------------------------------------------
package lzss_pkg;

  localparam int RING_ADDR_BITS = 12;
  localparam int RING_SIZE      = 1 << RING_ADDR_BITS;
  localparam int START_POSITION = 4078;
  localparam int FILL_BITS      = RING_ADDR_BITS + 1;
  localparam int LEN_BITS       = 24;
  localparam int MIN_MATCH      = 3;
  localparam int MAX_MATCH      = 18;
  localparam int CNT_BITS       = 5;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef logic [RING_ADDR_BITS-1:0] ring_addr_t;

  localparam ring_addr_t START_ADDR = ring_addr_t'(START_POSITION);

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_COPY = 1'b1
  } state_t;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_RESTART = 1'b1
  } kind_t;

  typedef struct packed {
    logic       en;
    ring_addr_t addr;
    logic [7:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic       en;
    ring_addr_t addr;
  } ram_rd_t;

endpackage

### rtl/lzss_ring_ram.sv
// ---------------------------------------------------------------------------
// lzss_ring_ram
// History ring: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lzss_ring_ram
  import lzss_pkg::*;
(
  input  logic       clk,
  input  ram_wr_t    wr,
  input  ram_rd_t    rd,
  output logic [7:0] rd_data
);

  logic [7:0] mem [RING_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read-first; a same-address collision is resolved by the caller
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### rtl/lzss_ring_decompressor_top.sv
// ---------------------------------------------------------------------------
// lzss_ring_decompressor_top
// LZSS decoder with a 4096-byte history ring and 3..18 byte matches.
// ---------------------------------------------------------------------------
//
//  Channel  Ports                       Carries
//  -------  --------------------------  ---------------------------------------
//  in       in_tvalid/tready/tdata/tuser compressed byte; tuser high = restart
//  out      out_tvalid/tready/tdata/     decoded byte; tlast = last of item,
//           tlast/tuser                  tuser = configured length reached
//  cfg      cfg_we/cfg_wdata             output_length, 24 bits
//
//  Flag byte, first match byte and restart are taken while idle; a literal or
//  match holds the input while the copy engine emits it, one byte per cycle
//  while out_tready allows, set by the single ring RAM read port and its registered read.
//  Reset/restart are instant: a fill count marks ring entries written since
//  the restart; entries outside it read as spaces, so no clearing pass.
//  Stalls: out_tready low holds the copy engine; the read stage keeps its
//  data and the next ring read waits. One item is decoded at a time.
//
`include "assert_macros.svh"

module lzss_ring_decompressor_top
  import lzss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] in_byte
  input  logic                in_tuser,   // [0] kind
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [7:0] out_byte
  output logic                out_tlast,  // last_of_run
  output logic                out_tuser,  // [0] stream_done
  // configuration
  input  logic                cfg_we,
  input  logic [LEN_BITS-1:0] cfg_wdata
);

  // parser and ring pointers
  state_t                state_r, state_nxt;
  ring_addr_t            wp_r, wp_nxt;
  logic [FILL_BITS-1:0]  fill_r, fill_nxt;
  logic [8:0]            flag_r, flag_nxt;
  logic                  phase_r, phase_nxt;
  logic [7:0]            low_r, low_nxt;
  logic [LEN_BITS-1:0]   produced_r, produced_nxt;
  logic [LEN_BITS-1:0]   out_len_r;

  // copy engine: read address, reads still to issue, read stage
  ring_addr_t            ra_r, ra_nxt;
  logic [CNT_BITS-1:0]   left_r, left_nxt;
  logic                  q_vld_r, q_vld_nxt;
  logic                  q_ovr_r, q_ovr_nxt;       // byte taken from q_ovr_byte_r
  logic [7:0]            q_ovr_byte_r, q_ovr_byte_nxt;
  logic                  q_chk_r, q_chk_nxt;       // ring entry was written

  // output register
  logic                  out_vld_r;
  logic [7:0]            out_byte_r;
  logic                  out_last_r;
  logic                  out_done_r;

  logic                  accept;
  logic                  data_acc;
  logic                  restart;
  logic                  flag_empty;
  logic                  tok_flag;
  logic                  tok_lit;
  logic                  tok_mlow;
  logic                  tok_mhigh;
  logic                  out_free;
  logic                  copy_act;
  logic                  emit;
  logic                  issue;
  logic                  done_now;
  logic                  last_now;
  logic                  fwd;
  logic                  entry_vld;
  ring_addr_t            ra_off;
  ring_addr_t            match_pos;
  logic [CNT_BITS-1:0]   match_len;
  logic [LEN_BITS-1:0]   produced_inc;
  logic [7:0]            q_byte;
  logic [7:0]            rd_data;
  ram_wr_t               ram_wr;
  ram_rd_t               ram_rd;

  // ---------------------------------------------------------------- decode
  assign accept     = in_tvalid && in_tready;
  assign restart    = accept && (kind_t'(in_tuser) == KIND_RESTART);
  // once the length is reached, data bytes are dropped without effect
  assign data_acc   = accept && (kind_t'(in_tuser) == KIND_DATA) &&
                      (produced_r < out_len_r);
  assign flag_empty = (flag_r[8:1] == 8'd0);
  assign tok_flag   = data_acc && !phase_r && flag_empty;
  assign tok_lit    = data_acc && !phase_r && !flag_empty && flag_r[0];
  assign tok_mlow   = data_acc && !phase_r && !flag_empty && !flag_r[0];
  assign tok_mhigh  = data_acc && phase_r;

  assign match_pos  = ring_addr_t'({in_tdata[7:4], low_r});
  assign match_len  = CNT_BITS'(in_tdata[3:0]) + CNT_BITS'(MIN_MATCH);

  // ---------------------------------------------------------------- engine
  assign out_free     = !out_vld_r || out_tready;
  assign q_byte       = q_ovr_r ? q_ovr_byte_r : (q_chk_r ? rd_data : SPACE_CHAR);
  assign emit         = copy_act && q_vld_r && out_free;
  assign produced_inc = produced_r + LEN_BITS'(1);
  assign done_now     = (produced_inc >= out_len_r);
  assign last_now     = (left_r == '0) || done_now;
  assign issue        = copy_act && (left_r != '0) &&
                        (!q_vld_r || (emit && !done_now));

  // entry valid when it lies within the fill run starting at START_ADDR
  assign ra_off    = ra_r - START_ADDR;
  assign entry_vld = ({1'b0, ra_off} < fill_r);
  // read hits the entry being written this cycle: take the written byte
  assign fwd       = emit && (ra_r == wp_r);

  assign ram_wr = '{en: emit, addr: wp_r, data: q_byte};
  assign ram_rd = '{en: issue, addr: ra_r};

  lzss_ring_ram u_ring (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (tok_lit || tok_mhigh) begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        if (emit && last_now) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    copy_act  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_COPY: copy_act  = 1'b1;
      default: begin
        in_tready = 1'b0;
        copy_act  = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    flag_nxt     = flag_r;
    phase_nxt    = phase_r;
    low_nxt      = low_r;
    produced_nxt = produced_r;
    if (restart) begin
      wp_nxt       = START_ADDR;
      fill_nxt     = '0;
      flag_nxt     = '0;
      phase_nxt    = 1'b0;
      low_nxt      = '0;
      produced_nxt = '0;
    end else begin
      if (tok_flag) begin
        flag_nxt = {1'b1, in_tdata};
      end
      if (tok_lit || tok_mlow) begin
        flag_nxt = {1'b0, flag_r[8:1]};
      end
      if (tok_mlow) begin
        low_nxt   = in_tdata;
        phase_nxt = 1'b1;
      end
      if (tok_mhigh) begin
        phase_nxt = 1'b0;
      end
      if (emit) begin
        wp_nxt       = wp_r + ring_addr_t'(1);
        produced_nxt = produced_inc;
        if (fill_r != FILL_BITS'(RING_SIZE)) begin
          fill_nxt = fill_r + FILL_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    ra_nxt         = ra_r;
    left_nxt       = left_r;
    q_vld_nxt      = q_vld_r;
    q_ovr_nxt      = q_ovr_r;
    q_ovr_byte_nxt = q_ovr_byte_r;
    q_chk_nxt      = q_chk_r;
    if (tok_lit) begin
      q_vld_nxt      = 1'b1;
      q_ovr_nxt      = 1'b1;
      q_ovr_byte_nxt = in_tdata;
      left_nxt       = '0;
    end else if (tok_mhigh) begin
      ra_nxt    = match_pos;
      left_nxt  = match_len;
      q_vld_nxt = 1'b0;
    end else if (issue) begin
      ra_nxt         = ra_r + ring_addr_t'(1);
      left_nxt       = left_r - CNT_BITS'(1);
      q_vld_nxt      = 1'b1;
      q_ovr_nxt      = fwd;
      q_ovr_byte_nxt = q_byte;
      q_chk_nxt      = entry_vld;
    end else if (emit) begin
      q_vld_nxt = 1'b0;
      if (done_now) begin
        left_nxt = '0;
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wp_r       <= START_ADDR;
      fill_r     <= '0;
      flag_r     <= '0;
      phase_r    <= 1'b0;
      low_r      <= '0;
      produced_r <= '0;
      out_len_r  <= '0;
      ra_r       <= '0;
      left_r     <= '0;
      q_vld_r    <= 1'b0;
      q_ovr_r    <= 1'b0;
      q_chk_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wp_r       <= wp_nxt;
      fill_r     <= fill_nxt;
      flag_r     <= flag_nxt;
      phase_r    <= phase_nxt;
      low_r      <= low_nxt;
      produced_r <= produced_nxt;
      ra_r       <= ra_nxt;
      left_r     <= left_nxt;
      q_vld_r    <= q_vld_nxt;
      q_ovr_r    <= q_ovr_nxt;
      q_chk_r    <= q_chk_nxt;
      if (cfg_we) begin
        out_len_r <= cfg_wdata;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    q_ovr_byte_r <= q_ovr_byte_nxt;
    if (emit) begin
      out_byte_r <= q_byte;
      out_last_r <= last_now;
      out_done_r <= done_now;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  // ---------------------------------------------------------------- checks
  `LZSS_ASSERT_IMP(a_idle_empty, in_tready, !q_vld_r && (left_r == '0), "input taken while copy pending")
  `LZSS_ASSERT_IMP(a_left_max, 1'b1, left_r <= CNT_BITS'(MAX_MATCH), "match count out of range")
  `LZSS_ASSERT_IMP(a_fill_max, 1'b1, fill_r <= FILL_BITS'(RING_SIZE), "fill count overrun")
  `LZSS_ASSERT_IMP(a_emit_room, emit, !out_vld_r || out_tready, "result overwritten before transfer")
  `LZSS_ASSERT_NXT(a_done_stop, emit && done_now, !q_vld_r && (left_r == '0) && (state_r == ST_IDLE), "copy continued past length")

endmodule

### sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZSS ring decompressor: a scoreboard class
// keeps its own ring, flag shifter and length counter, predicts every output
// byte from the accepted input transfers and checks the result stream.
// ---------------------------------------------------------------------------
module tb_top;
  import lzss_pkg::*;

  // Longest quiet stretch is the forced receiver hold-off (HOLD_CYCLES) plus
  // a few long gaps; the limit leaves several times that.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  // Settle time after the last owed byte covers a match and trailing no-result bytes.
  localparam int SETTLE_CYCLES  = 40;
  localparam int ITEM_TARGET    = 400;
  localparam int PRESSURE_AT    = 150;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] in_byte
  logic                in_tuser;   // [0] kind
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [7:0] out_byte
  logic                out_tlast;  // last_of_run
  logic                out_tuser;  // [0] stream_done
  logic                cfg_we;
  logic [LEN_BITS-1:0] cfg_wdata;

  lzss_ring_decompressor_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // one decoded byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } decoded_beat_t;

  // -------------------------------------------------------------------------
  // Scoreboard: shadow decoder state plus the queue of bytes still owed.
  // -------------------------------------------------------------------------
  class decode_scoreboard;
    logic [7:0]          ring [RING_SIZE];
    ring_addr_t          wr_ptr;
    logic [8:0]          flag_bits;   // pending control bits under a marker 1
    logic                in_match;    // low match byte taken, high one due
    logic [7:0]          match_low;
    logic [LEN_BITS-1:0] produced;
    logic [LEN_BITS-1:0] out_length;
    decoded_beat_t       pending_bytes[$];
    int                  errors;

    function new();
      out_length = '0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < RING_SIZE; i++) ring[i] = SPACE_CHAR;
      wr_ptr    = START_ADDR;
      flag_bits = '0;
      in_match  = 1'b0;
      match_low = '0;
      produced  = '0;
    endfunction

    function void set_length(logic [LEN_BITS-1:0] v);
      out_length = v;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch @%0t: %s", $realtime, msg);
    endfunction

    // write back into the ring, count, and queue the expected transfer
    function bit push_byte(logic [7:0] ch, bit end_of_item);
      decoded_beat_t beat;
      bit            done;
      ring[wr_ptr] = ch;
      wr_ptr++;
      produced++;
      done      = (produced >= out_length);
      beat.data = ch;
      beat.last = end_of_item || done;
      beat.done = done;
      pending_bytes.push_back(beat);
      return done;
    endfunction

    // returns 0 when the byte was dropped because the length is reached
    function bit absorb_input(kind_t k, logic [7:0] b);
      ring_addr_t pos;
      int         len;
      int         i;
      bit         stop;
      if (k == KIND_RESTART) begin
        restart();
        return 1'b1;
      end
      if (produced >= out_length) return 1'b0;
      if (!in_match) begin
        if (flag_bits <= 9'd1) begin
          flag_bits = {1'b1, b};
        end else if (flag_bits[0]) begin
          flag_bits = flag_bits >> 1;
          void'(push_byte(b, 1'b1));
        end else begin
          flag_bits = flag_bits >> 1;
          match_low = b;
          in_match  = 1'b1;
        end
      end else begin
        // copy one byte at a time so overlapping matches see fresh data
        in_match = 1'b0;
        pos      = {b[7:4], match_low};
        len      = int'(b[3:0]) + MIN_MATCH;
        i        = 0;
        stop     = 1'b0;
        while (!stop && i < len) begin
          stop = push_byte(ring[pos], i == len - 1);
          pos++;
          i++;
        end
      end
      return 1'b1;
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic done);
      decoded_beat_t exp;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %02h arrived with nothing expected", data));
        return;
      end
      exp = pending_bytes.pop_front();
      if (data !== exp.data)
        report($sformatf("out_byte %02h, expected %02h", data, exp.data));
      if (last !== exp.last)
        report($sformatf("last_of_run %b, expected %b", last, exp.last));
      if (done !== exp.done)
        report($sformatf("stream_done %b, expected %b", done, exp.done));
    endfunction

    function void final_check();
      if (pending_bytes.size() != 0)
        report($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
    endfunction
  endclass

  decode_scoreboard sb;

  int sent_items;
  bit src_gappy;
  bit hold_req;     // sender asks the receiver for the long hold-off
  bit hold_done;

  // clock, period 2
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: all sampling at the rising edge, in one process so a config
  // write, an input transfer and a result transfer are seen in a fixed order.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_length(cfg_wdata);
      if (in_tvalid && in_tready) begin
        void'(sb.absorb_input(kind_t'(in_tuser), in_tdata));
      end
      if (out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser);
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random tready gaps, with calm stretches, plus one long hold-off
  // counted here so the block backs up and stalls its input.
  // -------------------------------------------------------------------------
  initial begin
    int hold_left;
    int gap_left;
    int cyc;
    bit gappy;
    out_tready = 1'b0;
    hold_left  = 0;
    gap_left   = 0;
    cyc        = 0;
    gappy      = 1'b1;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 300 == 0) gappy = ($urandom_range(0, 2) != 0);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else begin
        out_tready <= 1'b1;
        if (gappy) gap_left = pick_gap();
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender tasks: entered and left at a falling edge.
  // -------------------------------------------------------------------------
  task automatic send_item(kind_t k, logic [7:0] b);
    int gap;
    gap = src_gappy ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_items++;
    if (sent_items % 64 == 0) src_gappy = ($urandom_range(0, 1) != 0);
  endtask

  // two-byte match token; position and length packed as the stream has them
  task automatic send_match(ring_addr_t pos, logic [3:0] len_code);
    send_item(KIND_DATA, pos[7:0]);
    send_item(KIND_DATA, {pos[11:8], len_code});
  endtask

  // flag byte and its tokens; now and then cut short to break the sequence
  task automatic send_block();
    logic [7:0] flag;
    ring_addr_t pos;
    logic [3:0] len_code;
    int         cut;
    int         r;
    flag = 8'($urandom);
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
    send_item(KIND_DATA, flag);
    for (int i = 0; i < cut; i++) begin
      if (flag[i]) begin
        send_item(KIND_DATA, 8'($urandom));
      end else begin
        // the write pointer is current here: the previous transfer is absorbed
        r = $urandom_range(0, 9);
        if (r < 4)      pos = ring_addr_t'($urandom);
        else if (r < 8) pos = sb.wr_ptr - ring_addr_t'($urandom_range(1, 20));
        else            pos = sb.wr_ptr - ring_addr_t'($urandom_range(0, 2));
        r = $urandom_range(0, 9);
        if (r < 2)      len_code = 4'hF;
        else if (r < 4) len_code = 4'h0;
        else            len_code = 4'($urandom);
        send_match(pos, len_code);
      end
    end
  endtask

  // stop offering, wait for every owed byte, then let trailing bytes settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // only called once drained
  task automatic write_length(logic [LEN_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Watchdog: counts cycles with no transfer and no config write.
  // -------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("FAIL lzss_ring_decompressor_top");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [LEN_BITS-1:0] len;
    bit                  pressure;
    int                  nblk;
    int                  r;
    sb         = new();
    sent_items = 0;
    src_gappy  = 1'b1;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_DATA;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // length is 0 out of reset: a data byte is dropped
    send_item(KIND_DATA, 8'hFF);
    drain();
    write_length(24'hFF_FFFF);

    // restart ignores its byte; flag A5 mixes literals and matches
    send_item(KIND_RESTART, 8'hFF);
    send_item(KIND_DATA, 8'hA5);
    send_item(KIND_DATA, 8'h00);          // literal, lands at the start position
    send_match(ring_addr_t'(START_POSITION), 4'hF); // 18 bytes, overlaps itself, wraps
    send_item(KIND_DATA, 8'hFF);          // literal
    send_match(12'h000, 4'h0);            // shortest match
    send_match(12'hFFF, 4'h0);            // read wraps at top of ring
    send_item(KIND_DATA, 8'h80);          // literal
    send_match(12'h123, 4'h0);            // untouched entries read as spaces
    send_item(KIND_DATA, 8'h7F);          // literal
    drain();

    // short length: restart inside a match, then a match cut off by the length
    write_length(24'd5);
    send_item(KIND_RESTART, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h55);
    send_item(KIND_RESTART, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_match(ring_addr_t'(START_POSITION), 4'hF); // stops after 5 bytes
    send_item(KIND_DATA, 8'h11);          // dropped, length reached
    send_item(KIND_DATA, 8'h22);
    drain();

    // length raised: decoding picks up where it stopped
    write_length(24'd8);
    send_match(12'h000, 4'h1);
    drain();

    // random phases of well-formed blocks with noise and broken sequences
    while (sent_items < ITEM_TARGET) begin
      pressure = !hold_done && sent_items >= PRESSURE_AT;
      r = $urandom_range(0, 9);
      if (pressure)   len = 24'hFF_FFFF;
      else if (r < 6) len = LEN_BITS'($urandom_range(1, 200));
      else if (r < 8) len = 24'hFF_FFFF;
      else if (r < 9) len = '0;
      else            len = LEN_BITS'($urandom);
      write_length(len);
      // skipping the restart carries state over from the last phase
      if (pressure || $urandom_range(0, 9) < 7) send_item(KIND_RESTART, 8'($urandom));
      nblk = pressure ? 12 : $urandom_range(1, 5);
      for (int b = 0; b < nblk; b++) begin
        if (pressure && b == 1) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(0, 99) < 85) begin
          send_block();
        end else begin
          repeat ($urandom_range(1, 4))
            send_item(($urandom_range(0, 7) == 0) ? KIND_RESTART : KIND_DATA,
                      8'($urandom));
        end
      end
      drain();
    end

    sb.final_check();
    if (sb.errors == 0) begin
      $display("PASS lzss_ring_decompressor_top");
    end else begin
      $display("FAIL lzss_ring_decompressor_top");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/lzss_pkg.sv
rtl/lzss_ring_ram.sv
rtl/lzss_ring_decompressor_top.sv
sim/tb_top.sv
